>>> sv/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  localparam int unsigned NUM_DIGITS = 8;
  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned NUM_W      = 32;

  // Exact reciprocals: floor(n / 1e8) = (n * C) >> 59 for any 32-bit n,
  // floor(r / 1e4) = (r * C) >> 41 for r below 2^27,
  // floor(x / 100) = (x * C) >> 19 for x below 2^14.
  localparam logic [32:0] RECIP_1E8  = 33'd5764607524;
  localparam int unsigned SHIFT_1E8  = 59;
  localparam logic [27:0] RECIP_1E4  = 28'd219902326;
  localparam int unsigned SHIFT_1E4  = 41;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int unsigned SHIFT_100  = 19;

  localparam logic [26:0] TEN_E8 = 27'd100000000;
  localparam logic [13:0] TEN_E4 = 14'd10000;
  localparam logic [6:0]  TEN_E2 = 7'd100;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [NUM_W-1:0] number;
  } ssd_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] digit_index;
    logic [SEG_W-1:0] segments;
  } ssd_rsp_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // Splits a value below 100 into its tens digit (high nibble) and ones digit.
  function automatic logic [7:0] split_pair(input logic [6:0] pair);
    logic [3:0] tens;
    logic [6:0] tens_x10;
    tens = 4'd0;
    for (int t = 1; t < 10; t++) begin
      if (pair >= 7'(10 * t)) begin
        tens = 4'(t);
      end
    end
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    return {tens, 4'(pair - tens_x10)};
  endfunction

endpackage

`default_nettype wire

>>> sv/seven_segment_number_display_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                          Moves
// request   in_valid_i/in_ready_o/in_req_i   command and number
// result    out_valid_o/out_ready_i/out_rsp_o digit index and segment pattern
//
// One request is taken every cycle unless the pipeline stalls. Every request
// runs through six stage registers; a scan result then enters the output
// register; a load writes the stored patterns in the same cycle a scan would.
// Reset clears the stored patterns and the scan position; the display is blank.
// A scan waiting on a full output register stalls the whole pipeline.

module seven_segment_number_display_core
  import ssd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire ssd_req_t in_req_i,
  output      logic     out_valid_o,
  input  wire logic     out_ready_i,
  output      ssd_rsp_t out_rsp_o
);

  logic             stall;
  logic             en;

  logic [5:0]       valid_q;
  cmd_e             cmd_q [6];

  logic [NUM_W-1:0] num0_q;
  logic [NUM_W-1:0] num1_q;
  logic [5:0]       quot1_q;
  logic [26:0]      rem2_q;
  logic [26:0]      rem3_q;
  logic [13:0]      hi3_q;
  logic [13:0]      grp4_q [2];
  logic [13:0]      grp5_q [2];
  logic [6:0]       top5_q [2];

  logic [64:0]      prod1;
  logic [31:0]      rem2_full;
  logic [54:0]      prod3;
  logic [26:0]      lo4_full;
  logic [26:0]      prod5 [2];

  logic [3:0]       dec [MAX_DIGITS];
  logic [SEG_W-1:0] new_pat [MAX_DIGITS];
  logic [SEG_W-1:0] pat_q [MAX_DIGITS];
  logic [SEG_W-1:0] pat_d [MAX_DIGITS];

  logic [IDX_W-1:0] scan_pos_q;
  logic [IDX_W-1:0] scan_pos_d;
  logic             load_fire;
  logic             scan_fire;

  logic             out_valid_q;
  logic             out_valid_d;
  ssd_rsp_t         out_rsp_q;
  ssd_rsp_t         out_rsp_d;

  assign stall      = valid_q[5] && (cmd_q[5] == CMD_SCAN) && out_valid_q && !out_ready_i;
  assign en         = !stall;
  assign in_ready_o = en;
  assign load_fire  = en && valid_q[5] && (cmd_q[5] == CMD_LOAD);
  assign scan_fire  = en && valid_q[5] && (cmd_q[5] == CMD_SCAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[4:0], in_valid_i};
    end
  end

  always_comb begin
    prod1     = 65'(num0_q) * 65'(RECIP_1E8);
    rem2_full = num1_q - 32'(quot1_q) * 32'(TEN_E8);
    prod3     = 55'(rem2_q) * 55'(RECIP_1E4);
    lo4_full  = rem3_q - 27'(hi3_q) * 27'(TEN_E4);
    for (int g = 0; g < 2; g++) begin
      prod5[g] = 27'(grp4_q[g]) * 27'(RECIP_100);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q[0]  <= in_req_i.command;
      num0_q    <= in_req_i.number;
      for (int s = 1; s < 6; s++) begin
        cmd_q[s] <= cmd_q[s-1];
      end
      quot1_q   <= prod1[SHIFT_1E8 +: 6];
      num1_q    <= num0_q;
      rem2_q    <= rem2_full[26:0];
      hi3_q     <= prod3[SHIFT_1E4 +: 14];
      rem3_q    <= rem2_q;
      grp4_q[0] <= hi3_q;
      grp4_q[1] <= lo4_full[13:0];
      for (int g = 0; g < 2; g++) begin
        top5_q[g] <= prod5[g][SHIFT_100 +: 7];
        grp5_q[g] <= grp4_q[g];
      end
    end
  end

  // Decimal digits, dec[0] least significant, then blanking and segment lookup.
  always_comb begin
    logic [6:0] low_pair;
    logic [7:0] split_hi;
    logic [7:0] split_lo;
    logic       shown;
    int         k;
    k     = 0;
    shown = 1'b0;
    for (int g = 0; g < 2; g++) begin
      low_pair = 7'(grp5_q[g] - 14'(top5_q[g]) * 14'(TEN_E2));
      split_hi = split_pair(top5_q[g]);
      split_lo = split_pair(low_pair);
      dec[7 - 4*g] = split_hi[7:4];
      dec[6 - 4*g] = split_hi[3:0];
      dec[5 - 4*g] = split_lo[7:4];
      dec[4 - 4*g] = split_lo[3:0];
    end
    for (int p = 0; p < MAX_DIGITS; p++) begin
      new_pat[p] = '0;
      if (p < NUM_DIGITS) begin
        k     = NUM_DIGITS - 1 - p;
        shown = (k == 0);
        for (int j = 0; j < MAX_DIGITS; j++) begin
          if (j >= k && j < NUM_DIGITS && dec[j] != 4'd0) begin
            shown = 1'b1;
          end
        end
        if (shown) begin
          new_pat[p] = seg_pattern(dec[IDX_W'(k)]);
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < MAX_DIGITS; p++) begin
      pat_d[p] = pat_q[p];
      if (load_fire && p < NUM_DIGITS) begin
        pat_d[p] = new_pat[p];
      end
    end
    scan_pos_d = scan_pos_q;
    if (scan_fire) begin
      if (scan_pos_q >= IDX_W'(NUM_DIGITS - 1)) begin
        scan_pos_d = '0;
      end else begin
        scan_pos_d = scan_pos_q + IDX_W'(1);
      end
    end
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    if (scan_fire) begin
      out_valid_d           = 1'b1;
      out_rsp_d.digit_index = scan_pos_q;
      out_rsp_d.segments    = pat_q[scan_pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MAX_DIGITS; p++) begin
        pat_q[p] <= '0;
      end
      scan_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int p = 0; p < MAX_DIGITS; p++) begin
        pat_q[p] <= pat_d[p];
      end
      scan_pos_q  <= scan_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

>>> sv/ssd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_checker
  import ssd_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire ssd_req_t in_req_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire ssd_rsp_t out_rsp_o
);

  logic [IDX_W-1:0] exp_idx_q;
  logic [3:0]       pending_q;
  logic             scan_in;
  logic             rsp_out;

  assign scan_in = in_valid_i && in_ready_o && (in_req_i.command == CMD_SCAN);
  assign rsp_out = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
      pending_q <= '0;
    end else begin
      if (rsp_out) begin
        if (out_rsp_o.digit_index >= IDX_W'(NUM_DIGITS - 1)) begin
          exp_idx_q <= '0;
        end else begin
          exp_idx_q <= out_rsp_o.digit_index + IDX_W'(1);
        end
      end
      pending_q <= pending_q + 4'(scan_in) - 4'(rsp_out);
    end
  end

  // A result stays offered with the same contents until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  // Scan results walk the digit positions in order and wrap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.digit_index == exp_idx_q)
    else $error("digit index out of sequence");

  // Every result answers an earlier scan request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without a pending scan");

  // The decimal point segment is never lit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_rsp_o.segments[SEG_W-1])
    else $error("top segment bit set");

endmodule

bind seven_segment_number_display_core ssd_checker u_ssd_checker (.*);

`default_nettype wire
